FILE: rtl/core/srpc_pkg.sv
// Package: types, register map and reset values of the stepper ramp position controller.
package srpc_pkg;

  localparam int unsigned TICK_COUNTER_BITS = 16;

  localparam int unsigned CfgAddrBits = 5;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [2:0] RegStepPeriod = 3'd0;
  localparam logic [2:0] RegRampLen    = 3'd1;
  localparam logic [2:0] RegPauseLen   = 3'd2;
  localparam logic [2:0] RegExtraSteps = 3'd3;
  localparam logic [2:0] RegSlotCount  = 3'd4;

  localparam logic [7:0]  StepPeriodRst = 8'd4;
  localparam logic [7:0]  RampLenRst    = 8'd8;
  localparam logic [15:0] PauseLenRst   = 16'd100;
  localparam logic [7:0]  ExtraStepsRst = 8'd10;
  localparam logic [7:0]  SlotCountRst  = 8'd12;

  typedef struct packed {
    logic       start_req;
    logic       pass_pulse;
    logic       barrier_blocked;
    logic [7:0] target_slot;
  } in_item_t;

  typedef struct packed {
    logic        step_pulse;
    logic [1:0]  phase;
    logic [7:0]  slot_now;
    logic [15:0] steps_since_mark;
    logic        done_pulse;
  } out_item_t;

endpackage

FILE: rtl/core/stepper_ramp_position_controller.sv
// Top level: per-tick ramp, run and stop sequencing of one stepper motor with slot tracking.
//
// One tick request is taken per clock cycle while the result register is empty or read
// out (out_ready_i). The request is held in an input register, then the whole tick update
// (pass queue, pause and tick counters, ramp interval compare through one 8x8 multiply, slot
// advance and the ramp-run-stop-idle cascade) is computed combinationally and written to the
// state and to the result register. A waiting result does not stop intake while the input
// register is free. Registers sit on the APB port at byte offsets 0, 4, 8, 12 and 16; the user
// must write them only while no tick is in flight, which the block itself does not enforce.
module stepper_ramp_position_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  srpc_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output srpc_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srpc_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [srpc_pkg::CfgDataBits-1:0]    pwdata,
  output logic [srpc_pkg::CfgDataBits-1:0]    prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    ModeIdle,
    ModeRamp,
    ModeRun,
    ModeStop,
    ModeFin
  } mode_e;

  localparam int unsigned TickBits = srpc_pkg::TICK_COUNTER_BITS;

  logic [7:0]  step_period_q, ramp_len_q, extra_steps_q, slot_count_q;
  logic [15:0] pause_len_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic                s1_valid_q;
  srpc_pkg::in_item_t  s1_data_q;
  logic                out_valid_q;
  srpc_pkg::out_item_t out_data_q, out_data_d;
  logic                adv, proc;

  mode_e                mode_q, mode_d, mode_prev_q, mode_prev_d;
  logic [15:0]          pause_left_q, pause_left_d;
  logic [TickBits-1:0]  tick_q, tick_d;
  logic [7:0]           ramp_left_q, ramp_left_d;
  logic [7:0]           extra_left_q, extra_left_d;
  logic [15:0]          tally_q, tally_d;
  logic [7:0]           slot_q, slot_d;
  logic [3:0]           pending_q, pending_d;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      srpc_pkg::RegStepPeriod: prdata = {24'd0, step_period_q};
      srpc_pkg::RegRampLen:    prdata = {24'd0, ramp_len_q};
      srpc_pkg::RegPauseLen:   prdata = {16'd0, pause_len_q};
      srpc_pkg::RegExtraSteps: prdata = {24'd0, extra_steps_q};
      srpc_pkg::RegSlotCount:  prdata = {24'd0, slot_count_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= srpc_pkg::StepPeriodRst;
      ramp_len_q    <= srpc_pkg::RampLenRst;
      pause_len_q   <= srpc_pkg::PauseLenRst;
      extra_steps_q <= srpc_pkg::ExtraStepsRst;
      slot_count_q  <= srpc_pkg::SlotCountRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srpc_pkg::RegStepPeriod: step_period_q <= pwdata[7:0];
        srpc_pkg::RegRampLen:    ramp_len_q    <= pwdata[7:0];
        srpc_pkg::RegPauseLen:   pause_len_q   <= pwdata[15:0];
        srpc_pkg::RegExtraSteps: extra_steps_q <= pwdata[7:0];
        srpc_pkg::RegSlotCount:  slot_count_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_valid_q || out_ready_i;
  assign proc        = s1_valid_q && adv;
  assign in_ready_o  = !s1_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    logic [7:0]  period;
    logic [7:0]  rlen;
    logic [15:0] prod;
    logic        stepped;
    logic        done;
    period       = (step_period_q == 8'd0) ? 8'd1 : step_period_q;
    rlen         = (ramp_len_q == 8'd0) ? 8'd1 : ramp_len_q;
    prod         = '0;
    stepped      = 1'b0;
    done         = 1'b0;
    mode_d       = mode_q;
    mode_prev_d  = mode_prev_q;
    pause_left_d = pause_left_q;
    tick_d       = tick_q;
    ramp_left_d  = ramp_left_q;
    extra_left_d = extra_left_q;
    tally_d      = tally_q;
    slot_d       = slot_q;
    pending_d    = pending_q;

    if (proc) begin
      if (s1_data_q.pass_pulse && pending_d != 4'd15) begin
        pending_d = pending_d + 4'd1;
      end
      if (mode_d == ModeIdle && s1_data_q.start_req) begin
        mode_d = ModeRamp;
      end
      if (mode_d != ModeIdle) begin
        if (pause_left_d != 16'd0) begin
          pause_left_d = pause_left_d - 16'd1;
        end else begin
          tick_d = tick_d + TickBits'(1);
        end
      end

      if (mode_d == ModeRamp) begin
        if (mode_prev_d != ModeRamp) begin
          mode_prev_d  = ModeRamp;
          ramp_left_d  = rlen;
          pause_left_d = pause_len_q;
          extra_left_d = extra_steps_q;
          tick_d       = '0;
          tally_d      = '0;
        end
        prod = 16'(period) * 16'(ramp_left_d);
        if (tick_d == TickBits'(prod) && pause_left_d == 16'd0) begin
          tick_d      = '0;
          ramp_left_d = ramp_left_d - 8'd1;
          if (ramp_left_d == 8'd0) begin
            mode_d = ModeRun;
          end
          stepped = 1'b1;
          tally_d = tally_d + 16'd1;
        end
      end

      if (mode_d == ModeRun) begin
        if (mode_prev_d != ModeRun) begin
          mode_prev_d = ModeRun;
          tick_d      = '0;
        end
        if (tick_d == TickBits'(period)) begin
          stepped = 1'b1;
          tally_d = tally_d + 16'd1;
          tick_d  = '0;
          if (pending_d != 4'd0) begin
            pending_d = pending_d - 4'd1;
            tally_d   = '0;
            slot_d    = slot_d + 8'd1;
            if (slot_d == slot_count_q) begin
              slot_d = '0;
            end
          end
        end
        if (slot_d == s1_data_q.target_slot && s1_data_q.barrier_blocked) begin
          if (extra_left_d == 8'd0) begin
            mode_d = ModeStop;
          end
          extra_left_d = extra_left_d - 8'd1;
        end
      end

      if (mode_d == ModeStop) begin
        if (mode_prev_d == ModeRun) begin
          mode_prev_d  = ModeStop;
          pause_left_d = pause_len_q;
        end
        if (pause_left_d == 16'd0) begin
          mode_d = ModeFin;
        end
      end

      if (mode_d == ModeFin) begin
        if (mode_prev_d == ModeStop) begin
          mode_prev_d = ModeFin;
          tick_d      = '0;
        end
        mode_d = ModeIdle;
        done   = 1'b1;
      end
    end

    out_data_d.step_pulse       = stepped;
    out_data_d.phase            = mode_d[1:0];
    out_data_d.slot_now         = slot_d;
    out_data_d.steps_since_mark = tally_d;
    out_data_d.done_pulse       = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      mode_q       <= ModeIdle;
      mode_prev_q  <= ModeFin;
      pause_left_q <= '0;
      tick_q       <= '0;
      ramp_left_q  <= '0;
      extra_left_q <= '0;
      tally_q      <= '0;
      slot_q       <= '0;
      pending_q    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      mode_q       <= mode_d;
      mode_prev_q  <= mode_prev_d;
      pause_left_q <= pause_left_d;
      tick_q       <= tick_d;
      ramp_left_q  <= ramp_left_d;
      extra_left_q <= extra_left_d;
      tally_q      <= tally_d;
      slot_q       <= slot_d;
      pending_q    <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (proc) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: rtl/core/srpc_checker.sv
// Checker: port-level assertions for the stepper ramp position controller, with its bind.
module srpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input srpc_pkg::out_item_t              out_data_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [srpc_pkg::CfgAddrBits-1:0] paddr,
  input logic [srpc_pkg::CfgDataBits-1:0] pwdata,
  input logic [srpc_pkg::CfgDataBits-1:0] prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_pulse |-> out_data_o.phase == 2'd0)
    else $error("move finished without returning to idle");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.step_pulse && out_data_o.phase == 2'd0
      |-> out_data_o.done_pulse)
    else $error("step issued while idle");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[4:2] == srpc_pkg::RegStepPeriod)
      ##1 (paddr[4:2] == srpc_pkg::RegStepPeriod)
      |-> prdata[7:0] == $past(pwdata[7:0]))
    else $error("step period readback mismatch");

endmodule

bind stepper_ramp_position_controller srpc_checker u_srpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
